@@ hw/rtl/nipd_pkg.sv @@
package nipd_pkg;

  // Newton corrections applied at most per item
  localparam int unsigned MaxSteps = 64;
  localparam int unsigned StepW    = $clog2(MaxSteps + 1);

  // one-hot sequencer states
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SQY  = 6'b000010,
    ST_SQX  = 6'b000100,
    ST_SQA  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_DONE = 6'b100000
  } nipd_state_e;

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } nipd_div_stat_t;

endpackage

@@ hw/rtl/nipd_if.sv @@
interface nipd_in_if #(
  parameter int unsigned COORD_WIDTH = 8
);
  logic                   valid;
  logic                   ready;
  logic [COORD_WIDTH-1:0] first_y;
  logic [COORD_WIDTH-1:0] first_x;
  logic [COORD_WIDTH-1:0] second_y;
  logic [COORD_WIDTH-1:0] second_x;

  modport source (output valid, first_y, first_x, second_y, second_x, input ready);
  modport sink   (input valid, first_y, first_x, second_y, second_x, output ready);
endinterface

interface nipd_out_if #(
  parameter int unsigned COORD_WIDTH = 8
);
  logic                 valid;
  logic                 ready;
  logic [COORD_WIDTH:0] distance;

  modport source (output valid, distance, input ready);
  modport sink   (input valid, distance, output ready);
endinterface

@@ hw/rtl/nipd_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module nipd_div #(
  parameter int unsigned NUM_W = 18,
  parameter int unsigned DEN_W = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [NUM_W-1:0]       num_i,
  input  logic [DEN_W-1:0]       den_i,
  output logic [NUM_W-1:0]       quo_o,
  output nipd_pkg::nipd_div_stat_t stat_o
);
  import nipd_pkg::*;

  localparam int unsigned CntW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic [DEN_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem_q, quo_q[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntW'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign quo_o       = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

@@ hw/rtl/newton_integer_point_distance.sv @@
// Channel   Dir  Payload                                    Handshake
// in_i      in   first_y, first_x, second_y, second_x      valid/ready
// out_o     out  distance                                   valid/ready
//
// An axis-aligned or equal pair goes straight to the output register; any other pair
// squares dy and dx, then runs passes through the bit-serial divider until one returns
// a zero correction or MaxSteps corrections have been applied.
// Ready is high only while the sequencer is idle; one item is in work at a time.
// The result sits in an output register, so the next item may start while it waits.
// Reset is asynchronous and clears the sequencer and output valid.
module newton_integer_point_distance #(
  parameter int unsigned COORD_WIDTH = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  nipd_in_if.sink    in_i,
  nipd_out_if.source out_o
);
  import nipd_pkg::*;

  localparam int unsigned EstW = COORD_WIDTH + 1;     // estimate and distance
  localparam int unsigned SqW  = 2 * COORD_WIDTH + 1; // dy^2 + dx^2
  localparam int unsigned PrW  = 2 * EstW;            // squarer output
  localparam int unsigned NumW = PrW + 1;             // signed numerator
  localparam int unsigned MagW = PrW;                 // numerator magnitude
  localparam int unsigned DenW = EstW + 1;            // 2 * estimate

  nipd_state_e state_q, state_d;

  logic [COORD_WIDTH-1:0] dy_q, dy_d, dx_q, dx_d;
  logic [EstW-1:0]        est_q, est_d;
  logic [SqW-1:0]         sq_q, sq_d;
  logic                   neg_q, neg_d;
  logic [StepW-1:0]       steps_q, steps_d;
  logic                   oval_q, oval_d;
  logic [EstW-1:0]        dist_q, dist_d;

  logic [COORD_WIDTH-1:0] in_dy, in_dx, in_hi, in_lo;
  logic [EstW-1:0]        sq_op;
  logic [PrW-1:0]         prod;
  logic signed [NumW-1:0] num;
  logic [MagW-1:0]        mag;
  logic                   div_start;
  logic [MagW-1:0]        quo;
  nipd_div_stat_t         div_stat;
  logic                   in_fire;
  logic                   out_free;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !oval_q || out_o.ready;

  assign in_dy = (in_i.first_y >= in_i.second_y) ? in_i.first_y - in_i.second_y
                                                  : in_i.second_y - in_i.first_y;
  assign in_dx = (in_i.first_x >= in_i.second_x) ? in_i.first_x - in_i.second_x
                                                  : in_i.second_x - in_i.first_x;
  assign in_hi = (in_dy > in_dx) ? in_dy : in_dx;
  assign in_lo = (in_dy > in_dx) ? in_dx : in_dy;

  // shared squarer: dy, then dx, then the current estimate each step
  always_comb begin
    case (state_q)
      ST_SQY:  sq_op = {1'b0, dy_q};
      ST_SQX:  sq_op = {1'b0, dx_q};
      default: sq_op = est_q;
    endcase
  end
  assign prod = PrW'(sq_op) * PrW'(sq_op);

  assign num = $signed({2'b00, sq_q}) - $signed({1'b0, prod});
  assign mag = num[NumW-1] ? MagW'(-num) : MagW'(num);

  assign div_start = (state_q == ST_SQA) && (steps_q != StepW'(MaxSteps));

  nipd_div #(
    .NUM_W (MagW),
    .DEN_W (DenW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mag),
    .den_i   ({est_q, 1'b0}),
    .quo_o   (quo),
    .stat_o  (div_stat)
  );

  always_comb begin
    state_d = state_q;
    dy_d    = dy_q;
    dx_d    = dx_q;
    est_d   = est_q;
    sq_d    = sq_q;
    neg_d   = neg_q;
    steps_d = steps_q;
    oval_d  = oval_q;
    dist_d  = dist_q;

    if (oval_q && out_o.ready) begin
      oval_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          dy_d    = in_dy;
          dx_d    = in_dx;
          est_d   = {1'b0, in_hi} + EstW'(in_lo >> 1);
          steps_d = '0;
          state_d = (in_dy == '0 || in_dx == '0) ? ST_DONE : ST_SQY;
        end
      end
      ST_SQY: begin
        sq_d    = SqW'(prod);
        state_d = ST_SQX;
      end
      ST_SQX: begin
        sq_d    = sq_q + SqW'(prod);
        state_d = ST_SQA;
      end
      ST_SQA: begin
        neg_d   = num[NumW-1];
        state_d = div_start ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          if (quo == '0) begin
            state_d = ST_DONE;
          end else begin
            est_d   = neg_q ? est_q - quo[EstW-1:0] : est_q + quo[EstW-1:0];
            steps_d = steps_q + 1'b1;
            state_d = ST_SQA;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          oval_d  = 1'b1;
          dist_d  = est_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      steps_q <= '0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      steps_q <= steps_d;
      oval_q  <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dy_q   <= dy_d;
    dx_q   <= dx_d;
    est_q  <= est_d;
    sq_q   <= sq_d;
    neg_q  <= neg_d;
    dist_q <= dist_d;
  end

  assign in_i.ready     = (state_q == ST_IDLE);
  assign out_o.valid    = oval_q;
  assign out_o.distance = dist_q;

  // step count stays within the safety bound
  a_steps_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    steps_q <= StepW'(MaxSteps))
    else $error("newton step count past bound");

  // the divider is running or finishing whenever the sequencer waits on it
  a_div_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (div_stat.busy || div_stat.done))
    else $error("sequencer waits on idle divider");

  // the estimate never reaches zero inside the Newton loop
  a_est_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQA || state_q == ST_DIV) |-> (est_q != '0))
    else $error("zero estimate in newton loop");

  // a new result is only loaded from the finishing state
  a_load_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!oval_q || out_o.ready) && oval_d |-> (state_q == ST_DONE))
    else $error("result loaded outside finishing state");

endmodule

@@ tb/tb.sv @@
module tb;
  import nipd_pkg::*;

  localparam int unsigned CoordW     = 8;
  localparam int unsigned RandItems  = 1120;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned DrainWait  = 200;
  localparam int unsigned MaxReports = 10;
  localparam int          CoordMax   = (1 << CoordW) - 1;

  logic clk_i;
  logic rst_ni;

  nipd_in_if  #(.COORD_WIDTH(CoordW)) in_bus  ();
  nipd_out_if #(.COORD_WIDTH(CoordW)) out_bus ();

  newton_integer_point_distance #(
    .COORD_WIDTH(CoordW)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  logic [CoordW:0] pending_distance[$];

  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned sent_count;
  int unsigned checked_count;
  int unsigned same_count;
  int unsigned axis_count;
  int unsigned newton_count;
  int unsigned sink_hold;
  bit          src_steady;
  bit          sink_steady;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_distance.size());
      $display("FAIL");
      $finish;
    end
  end

  // integer distance by max + min/2 start, then Newton corrections
  function automatic logic [CoordW:0] model_distance(input logic [CoordW-1:0] fy,
                                                     input logic [CoordW-1:0] fx,
                                                     input logic [CoordW-1:0] sy,
                                                     input logic [CoordW-1:0] sx);
    int dy;
    int dx;
    int hi;
    int lo;
    int est;
    int sq;
    int corr;
    dy  = (fy >= sy) ? int'(fy) - int'(sy) : int'(sy) - int'(fy);
    dx  = (fx >= sx) ? int'(fx) - int'(sx) : int'(sx) - int'(fx);
    hi  = (dy > dx) ? dy : dx;
    lo  = (dy > dx) ? dx : dy;
    est = hi + lo / 2;
    if (dy != 0 && dx != 0) begin
      sq = dy * dy + dx * dx;
      for (int s = 0; s < MaxSteps; s++) begin
        if (est <= 0) break;
        corr = (sq - est * est) / (2 * est);  // truncates toward zero
        if (corr == 0) break;
        est += corr;
      end
    end
    if (est < 0) est = 0;
    return est[CoordW:0];
  endfunction

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [CoordW-1:0] near_coord(input logic [CoordW-1:0] c);
    int v;
    v = int'(c) + $urandom_range(0, 12) - 6;
    if (v < 0) v = 0;
    if (v > CoordMax) v = CoordMax;
    return v[CoordW-1:0];
  endfunction

  task automatic send_points(input logic [CoordW-1:0] fy, input logic [CoordW-1:0] fx,
                             input logic [CoordW-1:0] sy, input logic [CoordW-1:0] sx);
    int unsigned gap;
    gap = src_steady ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_bus.valid = 1'b0;
    end
    @(negedge clk_i);
    in_bus.valid    = 1'b1;
    in_bus.first_y  = fy;
    in_bus.first_x  = fx;
    in_bus.second_y = sy;
    in_bus.second_x = sx;
    do @(posedge clk_i); while (!in_bus.ready);
    pending_distance.push_back(model_distance(fy, fx, sy, sx));
    sent_count++;
    if (fy == sy && fx == sx) same_count++;
    else if (fy == sy || fx == sx) axis_count++;
    else newton_count++;
  endtask

  // sink side: random stalls, steady stretches, and requested hold-offs
  initial begin
    int unsigned stall_left;
    stall_left    = 0;
    out_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (sink_hold > 0) begin
        out_bus.ready = 1'b0;
        sink_hold--;
      end else if (stall_left > 0) begin
        out_bus.ready = 1'b0;
        stall_left--;
      end else if (!sink_steady && $urandom_range(0, 3) == 0) begin
        out_bus.ready = 1'b0;
        stall_left    = pick_gap();
      end else begin
        out_bus.ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_distance
    logic [CoordW:0] want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (pending_distance.size() == 0) begin
        error_count++;
        if (error_count <= MaxReports)
          $display("unexpected transaction: distance %0d", out_bus.distance);
      end else begin
        want = pending_distance.pop_front();
        checked_count++;
        if (out_bus.distance !== want) begin
          error_count++;
          if (error_count <= MaxReports)
            $display("distance mismatch on result %0d: expected %0d, got %0d",
                     checked_count, want, out_bus.distance);
        end
      end
    end
  end

  task automatic test_directed();
    logic [CoordW-1:0] top;
    top = CoordMax[CoordW-1:0];
    send_points(0, 0, 0, 0);              // same point
    send_points(top, top, top, top);
    send_points(100, 37, 100, 37);
    send_points(0, 0, 0, top);            // axis aligned
    send_points(0, 0, top, 0);
    send_points(top, 0, 0, 0);
    send_points(0, top, 0, 0);
    send_points(5, 9, 5, 10);
    send_points(0, 0, top, top);          // full diagonal
    send_points(top, top, 0, 0);
    send_points(0, top, top, 0);
    send_points(top, 0, 0, top);
    send_points(0, 0, 1, 1);
    send_points(1, 2, 0, 0);
    send_points(0, 0, 1, top);
    send_points(top, 1, 0, 0);
    send_points(10, 10, 13, 14);          // 3-4-5
    send_points(200, 50, 195, 62);        // 5-12-13
    send_points(8'haa, 8'h55, 8'h55, 8'haa);
    send_points(8'h55, 8'haa, 8'haa, 8'h55);
  endtask

  // sink stops for a long stretch while the sender keeps offering items
  task automatic test_backpressure();
    src_steady = 1'b1;
    sink_hold  = 300;
    repeat (8)
      send_points(CoordW'($urandom_range(0, CoordMax)), CoordW'($urandom_range(0, CoordMax)),
                  CoordW'($urandom_range(0, CoordMax)), CoordW'($urandom_range(0, CoordMax)));
    src_steady = 1'b0;
  endtask

  task automatic test_random();
    logic [CoordW-1:0] fy;
    logic [CoordW-1:0] fx;
    logic [CoordW-1:0] sy;
    logic [CoordW-1:0] sx;
    int unsigned       kind;
    for (int unsigned n = 0; n < RandItems; n++) begin
      // switch at random between stretches with and without idling
      if (n % 100 == 0) begin
        src_steady  = ($urandom_range(0, 2) == 0);
        sink_steady = ($urandom_range(0, 2) == 0);
      end
      fy   = CoordW'($urandom_range(0, CoordMax));
      fx   = CoordW'($urandom_range(0, CoordMax));
      sy   = CoordW'($urandom_range(0, CoordMax));
      sx   = CoordW'($urandom_range(0, CoordMax));
      kind = $urandom_range(0, 99);
      if (kind >= 70 && kind < 82) begin
        sy = near_coord(fy);
        sx = near_coord(fx);
      end else if (kind >= 82 && kind < 92) begin
        if (kind[0]) sy = fy;
        else sx = fx;
      end else if (kind >= 92 && kind < 96) begin
        sy = fy;
        sx = fx;
      end else if (kind >= 96) begin
        fy = {CoordW{kind[0]}};
        fx = {CoordW{kind[1]}};
        sy = {CoordW{~kind[0]}};
        sx = {CoordW{$urandom_range(0, 1) == 1}};
      end
      send_points(fy, fx, sy, sx);
    end
    src_steady  = 1'b0;
    sink_steady = 1'b0;
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_bus.valid    = 1'b0;
    in_bus.first_y  = '0;
    in_bus.first_x  = '0;
    in_bus.second_y = '0;
    in_bus.second_x = '0;
    cycle_count     = 0;
    error_count     = 0;
    sent_count      = 0;
    checked_count   = 0;
    same_count      = 0;
    axis_count      = 0;
    newton_count    = 0;
    sink_hold       = 0;
    src_steady      = 1'b0;
    sink_steady     = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_backpressure();
    test_random();

    @(negedge clk_i);
    in_bus.valid = 1'b0;
    while (pending_distance.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("sent %0d point pairs: %0d same point, %0d axis aligned, %0d needing Newton steps",
             sent_count, same_count, axis_count, newton_count);
    $display("checked %0d distances with random stalls and one long output hold-off, %0d errors",
             checked_count, error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/nipd_pkg.sv
hw/rtl/nipd_if.sv
hw/rtl/nipd_div.sv
hw/rtl/newton_integer_point_distance.sv
tb/tb.sv
